### sv/dept_pkg.sv
// ----------------------------------------------------------------------------
// dept_pkg
// Shared types and constants of the debounced encoder position tracker.
// ----------------------------------------------------------------------------
package dept_pkg;

    // widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DEB_W   = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned STEP_W  = 8;
    localparam int unsigned ANGLE_W = 11;
    localparam int unsigned SUM_W   = 12;
    localparam int unsigned OUT_W   = 9;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned DATA_W  = 16;

    // angle limits and re-arm threshold
    localparam logic signed [SUM_W-1:0]   ANGLE_MAX   = 12'sd359;
    localparam logic signed [SUM_W-1:0]   ANGLE_MIN   = -12'sd360;
    localparam logic signed [SUM_W-1:0]   REARM_CW_AT = 12'sd30;
    localparam logic signed [ANGLE_W-1:0] FULL_TURN   = 11'sd360;
    localparam logic [COUNT_W-1:0]        TURN_SAT    = 8'd255;

    // direction codes
    localparam logic DIR_CW  = 1'b0;
    localparam logic DIR_CCW = 1'b1;

    // register reset values
    localparam logic              RST_AUTO_REV  = 1'b0;
    localparam logic [DEB_W-1:0]  RST_POS_DEB   = 16'd50;
    localparam logic [DEB_W-1:0]  RST_ZERO_DEB  = 16'd5000;
    localparam logic [COUNT_W-1:0] RST_TURNS    = 8'd1;
    localparam logic [STEP_W-1:0] RST_STEP      = 8'd10;

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_AUTO_REVERSE  = 3'd0,
        REG_POS_DEBOUNCE  = 3'd1,
        REG_ZERO_DEBOUNCE = 3'd2,
        REG_TURNS_PER_REV = 3'd3,
        REG_DEG_PER_EDGE  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic               auto_reverse_enable;
        logic [DEB_W-1:0]   position_debounce_ms;
        logic [DEB_W-1:0]   zero_debounce_ms;
        logic [COUNT_W-1:0] turns_per_reversal;
        logic [STEP_W-1:0]  degrees_per_edge;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              position_edge;
        logic              zero_edge;
        logic              set_direction;
        logic              new_direction;
        logic              clear_position;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] angle_degrees;
        logic             turn_direction;
        logic             zero_seen;
        logic             position_accepted;
        logic             zero_accepted;
    } t_out_item;

endpackage

### sv/dept_if.sv
// ----------------------------------------------------------------------------
// dept interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface dept_in_if;
    logic               valid;
    logic               ready;
    dept_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dept_out_if;
    logic                valid;
    logic                ready;
    dept_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dept_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dept_pkg::IDX_W-1:0]     index;
    logic [dept_pkg::DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/debounced_encoder_position_tracker_core.sv
// ----------------------------------------------------------------------------
// debounced_encoder_position_tracker_core
// Debounced encoder angle tracker with zero mark and auto reversal.
// ----------------------------------------------------------------------------
// Each request is registered, updated against the tracker state in one pass of
// logic and its result registered, so the block takes one request per clock
// while the result register is free or being read; a held result stalls the
// input only once the input register is full too. Register writes are taken
// every cycle and must come while idle.
module debounced_encoder_position_tracker_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dept_in_if.sink   i_in,
    dept_cfg_if.sink  i_cfg,
    dept_out_if.source o_out
);
    import dept_pkg::*;

    t_cfg      cfg;
    t_out_item res;

    logic      r_s1_valid;
    logic      n_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    logic      s1_adv;
    logic      in_take;

    dept_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    dept_tracker u_trk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (s1_adv),
        .i_item  (r_s1_item),
        .o_res   (res)
    );

    // stage handshakes
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_take    = i_in.valid && i_in.ready;

    assign n_s1_valid  = in_take || (r_s1_valid && !s1_adv);
    assign n_out_valid = s1_adv || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item <= i_in.data;
        end
        if (s1_adv) begin
            r_out <= res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // checks
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.angle_degrees <= 9'd359))
        else $error("folded angle out of range");

    a_in_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty result register");

    a_pos_needs_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && res.position_accepted) |-> r_s1_item.position_edge)
        else $error("position accepted without an edge");

    a_zero_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> (r_out.zero_seen == $past(r_s1_item.zero_edge)))
        else $error("zero notification lost");

endmodule

### sv/dept_cfg_regs.sv
// ----------------------------------------------------------------------------
// dept_cfg_regs
// Configuration register file, written one register per request.
// ----------------------------------------------------------------------------
module dept_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dept_cfg_if.sink       i_cfg,
    output dept_pkg::t_cfg o_cfg
);
    import dept_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register decode, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_AUTO_REVERSE:  n_cfg.auto_reverse_enable  = i_cfg.data[0];
                REG_POS_DEBOUNCE:  n_cfg.position_debounce_ms = i_cfg.data[DEB_W-1:0];
                REG_ZERO_DEBOUNCE: n_cfg.zero_debounce_ms     = i_cfg.data[DEB_W-1:0];
                REG_TURNS_PER_REV: n_cfg.turns_per_reversal   = i_cfg.data[COUNT_W-1:0];
                REG_DEG_PER_EDGE:  n_cfg.degrees_per_edge     = i_cfg.data[STEP_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_reverse_enable  <= RST_AUTO_REV;
            r_cfg.position_debounce_ms <= RST_POS_DEB;
            r_cfg.zero_debounce_ms     <= RST_ZERO_DEB;
            r_cfg.turns_per_reversal   <= RST_TURNS;
            r_cfg.degrees_per_edge     <= RST_STEP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/dept_tracker.sv
// ----------------------------------------------------------------------------
// dept_tracker
// Tracker state and the single-pass update for one registered item.
// ----------------------------------------------------------------------------
module dept_tracker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dept_pkg::t_cfg      i_cfg,
    input  logic                i_fire,
    input  dept_pkg::t_in_item  i_item,
    output dept_pkg::t_out_item o_res
);
    import dept_pkg::*;

    logic signed [ANGLE_W-1:0] r_angle;
    logic                      r_dir;
    logic                      r_cw_ok;
    logic                      r_ccw_ok;
    logic [COUNT_W-1:0]        r_turns;
    logic [TIME_W-1:0]         r_last_pos;
    logic [TIME_W-1:0]         r_last_zero;

    logic signed [ANGLE_W-1:0] n_angle;
    logic                      n_dir;
    logic                      n_cw_ok;
    logic                      n_ccw_ok;
    logic [COUNT_W-1:0]        n_turns;
    logic [TIME_W-1:0]         n_last_pos;
    logic [TIME_W-1:0]         n_last_zero;

    logic [TIME_W-1:0]         pos_elapsed;
    logic [TIME_W-1:0]         zero_elapsed;
    logic                      pos_ok;
    logic                      zero_ok;
    logic signed [SUM_W-1:0]   step;
    logic signed [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0]        turns_inc;
    logic                      reverse;
    logic signed [ANGLE_W-1:0] folded;

    // debounce against the last accepted edge, modulo 2^32
    assign pos_elapsed  = i_item.now_ms - r_last_pos;
    assign zero_elapsed = i_item.now_ms - r_last_zero;
    assign pos_ok  = i_item.position_edge &&
                     (pos_elapsed >= {{(TIME_W-DEB_W){1'b0}}, i_cfg.position_debounce_ms});
    assign zero_ok = i_item.zero_edge &&
                     (zero_elapsed >= {{(TIME_W-DEB_W){1'b0}}, i_cfg.zero_debounce_ms});
    assign step = $signed({{(SUM_W-STEP_W){1'b0}}, i_cfg.degrees_per_edge});
    assign turns_inc = (r_turns == TURN_SAT) ? r_turns : r_turns + COUNT_W'(1);

    always_comb begin
        n_angle     = r_angle;
        n_dir       = r_dir;
        n_cw_ok     = r_cw_ok;
        n_ccw_ok    = r_ccw_ok;
        n_turns     = r_turns;
        n_last_pos  = r_last_pos;
        n_last_zero = r_last_zero;
        sum         = '0;
        reverse     = 1'b0;

        // manual direction command
        if (i_item.set_direction) begin
            n_dir = i_item.new_direction;
            if (i_item.new_direction == DIR_CW) begin
                n_ccw_ok = 1'b0;
            end else begin
                n_cw_ok = 1'b0;
            end
        end

        // clear before the edges
        if (i_item.clear_position) begin
            n_angle = '0;
        end

        // position step with saturation and re-arm
        if (pos_ok) begin
            n_last_pos = i_item.now_ms;
            if (n_dir == DIR_CCW) begin
                sum = {n_angle[ANGLE_W-1], n_angle} + step;
            end else begin
                sum = {n_angle[ANGLE_W-1], n_angle} - step;
            end
            if (sum > ANGLE_MAX) begin
                sum = ANGLE_MAX;
            end else if (sum < ANGLE_MIN) begin
                sum = ANGLE_MIN;
            end
            n_angle = sum[ANGLE_W-1:0];
            if (sum >= REARM_CW_AT) begin
                n_cw_ok = 1'b1;
            end else begin
                n_ccw_ok = 1'b1;
            end
        end

        // zero mark: reset angle, count the turn, maybe reverse
        if (zero_ok) begin
            n_last_zero = i_item.now_ms;
            n_angle     = '0;
            n_turns     = turns_inc;
            reverse = i_cfg.auto_reverse_enable &&
                      (turns_inc >= i_cfg.turns_per_reversal) &&
                      ((n_dir == DIR_CW) ? n_ccw_ok : n_cw_ok);
            if (reverse) begin
                n_dir   = ~n_dir;
                n_turns = '0;
                if (n_dir == DIR_CW) begin
                    n_ccw_ok = 1'b0;
                end else begin
                    n_cw_ok = 1'b0;
                end
            end
        end
    end

    // fold into 0..359
    assign folded = n_angle[ANGLE_W-1] ? (n_angle + FULL_TURN) : n_angle;

    assign o_res.angle_degrees     = folded[OUT_W-1:0];
    assign o_res.turn_direction    = n_dir;
    assign o_res.zero_seen         = i_item.zero_edge;
    assign o_res.position_accepted = pos_ok;
    assign o_res.zero_accepted     = zero_ok;

    // state commits when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle     <= '0;
            r_dir       <= DIR_CW;
            r_cw_ok     <= 1'b0;
            r_ccw_ok    <= 1'b0;
            r_turns     <= '0;
            r_last_pos  <= '0;
            r_last_zero <= '0;
        end else if (i_fire) begin
            r_angle     <= n_angle;
            r_dir       <= n_dir;
            r_cw_ok     <= n_cw_ok;
            r_ccw_ok    <= n_ccw_ok;
            r_turns     <= n_turns;
            r_last_pos  <= n_last_pos;
            r_last_zero <= n_last_zero;
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the debounced encoder position tracker. Directed
// encoder requests cover debounce edges, wrap, saturation and auto reversal.
// Random turning sequences then run under several register settings while
// both channels idle and stall. Every result is checked against an in-bench
// tracker model.
// ----------------------------------------------------------------------------
module tb_top;
    import dept_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [SUM_W-1:0] REARM_CCW_AT = 12'sd330;

    logic i_clk;
    logic i_rst_n;

    dept_in_if  enc_in ();
    dept_out_if enc_out ();
    dept_cfg_if enc_cfg ();

    debounced_encoder_position_tracker_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (enc_in),
        .i_cfg   (enc_cfg),
        .o_out   (enc_out)
    );

    // tracker model state and register copy
    t_cfg                      trk_cfg;
    logic signed [ANGLE_W-1:0] trk_angle;
    logic                      trk_dir;
    logic                      trk_cw_ok;
    logic                      trk_ccw_ok;
    logic [COUNT_W-1:0]        trk_turns;
    logic [TIME_W-1:0]         trk_last_pos;
    logic [TIME_W-1:0]         trk_last_zero;

    t_in_item  encoder_events[$];
    t_out_item angle_reports[$];

    int          errors;
    int          events_issued;
    int          results_seen;
    int          cycle_count;
    int          burst_left;
    int          gap_left;
    int          hold_left;
    int          ready_mode;
    int unsigned ready_phase;
    bit          sender_calm;
    logic [TIME_W-1:0] now_cursor;

    // clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // manual or automatic direction change drops the opposite re-arm flag
    function automatic void steer(input logic dir);
        trk_dir = dir;
        if (dir == DIR_CW)
            trk_ccw_ok = 1'b0;
        else
            trk_cw_ok = 1'b0;
    endfunction

    // next angle report for one encoder request
    function automatic t_out_item track_encoder(input t_in_item ev);
        t_out_item                 res;
        logic signed [SUM_W-1:0]   sum;
        logic signed [SUM_W-1:0]   delta;
        logic signed [ANGLE_W-1:0] folded;
        logic [TIME_W-1:0]         since;
        logic                      pos_ok;
        logic                      zero_ok;
        pos_ok  = 1'b0;
        zero_ok = 1'b0;
        if (ev.set_direction)
            steer(ev.new_direction);
        if (ev.clear_position)
            trk_angle = '0;

        // position edge, debounced on wrapped elapsed time
        since = ev.now_ms - trk_last_pos;
        if (ev.position_edge && since >= TIME_W'(trk_cfg.position_debounce_ms)) begin
            pos_ok       = 1'b1;
            trk_last_pos = ev.now_ms;
            sum   = trk_angle;
            delta = $signed({{(SUM_W-STEP_W){1'b0}}, trk_cfg.degrees_per_edge});
            if (trk_dir == DIR_CCW)
                sum = sum + delta;
            else
                sum = sum - delta;
            if (sum > ANGLE_MAX)
                sum = ANGLE_MAX;
            else if (sum < ANGLE_MIN)
                sum = ANGLE_MIN;
            trk_angle = sum[ANGLE_W-1:0];
            if (sum >= REARM_CW_AT)
                trk_cw_ok = 1'b1;
            else if (sum <= REARM_CCW_AT)
                trk_ccw_ok = 1'b1;
        end

        // zero mark: clear angle, count turn, maybe reverse
        since = ev.now_ms - trk_last_zero;
        if (ev.zero_edge && since >= TIME_W'(trk_cfg.zero_debounce_ms)) begin
            zero_ok       = 1'b1;
            trk_last_zero = ev.now_ms;
            trk_angle     = '0;
            if (trk_turns != TURN_SAT)
                trk_turns = trk_turns + COUNT_W'(1);
            if (trk_cfg.auto_reverse_enable && trk_turns >= trk_cfg.turns_per_reversal &&
                ((trk_dir == DIR_CW && trk_ccw_ok) || (trk_dir == DIR_CCW && trk_cw_ok))) begin
                steer(~trk_dir);
                trk_turns = '0;
            end
        end

        folded = trk_angle;
        if (folded < 0)
            folded = folded + FULL_TURN;
        res.angle_degrees     = folded[OUT_W-1:0];
        res.turn_direction    = trk_dir;
        res.zero_seen         = ev.zero_edge;
        res.position_accepted = pos_ok;
        res.zero_accepted     = zero_ok;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [OUT_W-1:0] want_v,
                               input logic [OUT_W-1:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
        end
    endtask

    // register write request, model copy updated on handshake
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        enc_cfg.valid <= 1'b1;
        enc_cfg.index <= idx;
        enc_cfg.data  <= val;
        do @(posedge i_clk); while (!enc_cfg.ready);
        case (idx)
            REG_AUTO_REVERSE:  trk_cfg.auto_reverse_enable  = val[0];
            REG_POS_DEBOUNCE:  trk_cfg.position_debounce_ms = val;
            REG_ZERO_DEBOUNCE: trk_cfg.zero_debounce_ms     = val;
            REG_TURNS_PER_REV: trk_cfg.turns_per_reversal   = val[COUNT_W-1:0];
            REG_DEG_PER_EDGE:  trk_cfg.degrees_per_edge     = val[STEP_W-1:0];
            default: ;
        endcase
        enc_cfg.valid <= 1'b0;
    endtask

    // all five registers, unused upper data bits randomized
    task automatic load_settings(input logic auto_rev, input logic [DEB_W-1:0] pos_deb,
                                 input logic [DEB_W-1:0] zero_deb,
                                 input logic [COUNT_W-1:0] turns,
                                 input logic [STEP_W-1:0] step);
        write_reg(REG_AUTO_REVERSE, {15'($urandom), auto_rev});
        write_reg(REG_POS_DEBOUNCE, pos_deb);
        write_reg(REG_ZERO_DEBOUNCE, zero_deb);
        write_reg(REG_TURNS_PER_REV, {8'($urandom), turns});
        write_reg(REG_DEG_PER_EDGE, {8'($urandom), step});
    endtask

    task automatic push_event(input logic [TIME_W-1:0] now, input logic pos, input logic zero,
                              input logic set_dir, input logic new_dir, input logic clr);
        t_in_item ev;
        ev.now_ms         = now;
        ev.position_edge  = pos;
        ev.zero_edge      = zero;
        ev.set_direction  = set_dir;
        ev.new_direction  = new_dir;
        ev.clear_position = clr;
        encoder_events.push_back(ev);
        events_issued++;
    endtask

    // turning sequence: time mostly steps near the position debounce
    task automatic spin_encoder(input int count, input int zero_pct);
        int unsigned r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 2)
                now_cursor = $urandom;
            else if (r < 10)
                now_cursor += $urandom_range(0, 2 * int'(trk_cfg.zero_debounce_ms) + 1);
            else
                now_cursor += $urandom_range(0, 2 * int'(trk_cfg.position_debounce_ms) + 1);
            push_event(now_cursor, $urandom_range(0, 99) < 75, $urandom_range(0, 99) < zero_pct,
                       $urandom_range(0, 99) < 8, 1'($urandom), $urandom_range(0, 99) < 4);
        end
    endtask

    // wait until every request has its result, then let the pipeline drain
    task automatic settle();
        while (results_seen < events_issued)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // request driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            enc_in.valid <= 1'b0;
        end else begin
            if (enc_in.valid && enc_in.ready)
                angle_reports.push_back(track_encoder(enc_in.data));
            if (!enc_in.valid || enc_in.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    enc_in.valid <= 1'b0;
                end else if (encoder_events.size() > 0) begin
                    enc_in.data  <= encoder_events.pop_front();
                    enc_in.valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 32);
                        if (sender_calm || $urandom_range(0, 3) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, 6);
                    end
                end else begin
                    enc_in.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and stall pattern
    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        if (!i_rst_n) begin
            enc_out.ready <= 1'b0;
        end else begin
            if (enc_out.valid && enc_out.ready) begin
                if (angle_reports.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual angle %0d", $time,
                             enc_out.data.angle_degrees);
                end else begin
                    want = angle_reports.pop_front();
                    check_field("angle_degrees", want.angle_degrees,
                                enc_out.data.angle_degrees);
                    check_field("turn_direction", OUT_W'(want.turn_direction),
                                OUT_W'(enc_out.data.turn_direction));
                    check_field("zero_seen", OUT_W'(want.zero_seen),
                                OUT_W'(enc_out.data.zero_seen));
                    check_field("position_accepted", OUT_W'(want.position_accepted),
                                OUT_W'(enc_out.data.position_accepted));
                    check_field("zero_accepted", OUT_W'(want.zero_accepted),
                                OUT_W'(enc_out.data.zero_accepted));
                end
                results_seen++;
                // long hold-off so the block backs up into its input
                if (results_seen == 300 || results_seen == 1500)
                    hold_left = 250;
            end
            ready_phase++;
            if (hold_left > 0) begin
                hold_left--;
                enc_out.ready <= 1'b0;
            end else begin
                case (ready_mode)
                    0: enc_out.ready <= 1'b1;
                    1: enc_out.ready <= $urandom_range(0, 3) != 0;
                    2: enc_out.ready <= (ready_phase % 7) > 2;
                    default: enc_out.ready <= $urandom_range(0, 9) < 3;
                endcase
            end
        end
    end

    // cycle limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    // reset, register settings and stimulus
    initial begin
        i_rst_n       = 1'b0;
        enc_in.valid  = 1'b0;
        enc_in.data   = '0;
        enc_cfg.valid = 1'b0;
        enc_cfg.index = '0;
        enc_cfg.data  = '0;
        enc_out.ready = 1'b0;
        errors        = 0;
        events_issued = 0;
        results_seen  = 0;
        burst_left    = 1;
        gap_left      = 0;
        hold_left     = 0;
        ready_mode    = 0;
        ready_phase   = 0;
        sender_calm   = 1'b0;
        now_cursor    = '0;

        trk_cfg.auto_reverse_enable  = RST_AUTO_REV;
        trk_cfg.position_debounce_ms = RST_POS_DEB;
        trk_cfg.zero_debounce_ms     = RST_ZERO_DEB;
        trk_cfg.turns_per_reversal   = RST_TURNS;
        trk_cfg.degrees_per_edge     = RST_STEP;
        trk_angle     = '0;
        trk_dir       = DIR_CW;
        trk_cw_ok     = 1'b0;
        trk_ccw_ok    = 1'b0;
        trk_turns     = '0;
        trk_last_pos  = '0;
        trk_last_zero = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: debounce at start, wrap of the timestamp, clear
        push_event(32'd0, 1'b1, 1'b1, 1'b0, DIR_CW, 1'b0);
        push_event(32'd50, 1'b1, 1'b0, 1'b0, DIR_CW, 1'b0);
        push_event(32'd60, 1'b1, 1'b0, 1'b0, DIR_CW, 1'b0);
        push_event(32'd5000, 1'b1, 1'b1, 1'b0, DIR_CW, 1'b0);
        push_event(32'd5001, 1'b1, 1'b0, 1'b1, DIR_CCW, 1'b0);
        push_event(32'd5100, 1'b1, 1'b0, 1'b0, DIR_CW, 1'b0);
        push_event(32'd5200, 1'b1, 1'b0, 1'b0, DIR_CW, 1'b1);
        push_event(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, DIR_CW, 1'b1);
        push_event(32'd20, 1'b1, 1'b0, 1'b0, DIR_CW, 1'b0);
        push_event(32'd49, 1'b1, 1'b0, 1'b0, DIR_CW, 1'b0);
        push_event(32'd49, 1'b0, 1'b0, 1'b0, DIR_CW, 1'b0);
        settle();

        // writes to unused indexes must be ignored
        for (int k = int'(REG_DEG_PER_EDGE) + 1; k < (1 << IDX_W); k++)
            write_reg(IDX_W'(k), 16'($urandom));

        // no debounce, big step: upward saturation, the lower limit and auto reversal
        load_settings(1'b1, 16'd0, 16'd0, 8'd1, 8'd180);
        push_event(32'd100, 1'b1, 1'b0, 1'b1, DIR_CCW, 1'b0);
        push_event(32'd100, 1'b1, 1'b0, 1'b0, DIR_CW, 1'b0);
        push_event(32'd100, 1'b0, 1'b1, 1'b0, DIR_CW, 1'b0);
        push_event(32'd100, 1'b1, 1'b0, 1'b0, DIR_CW, 1'b0);
        push_event(32'd100, 1'b1, 1'b0, 1'b0, DIR_CW, 1'b0);
        push_event(32'd100, 1'b1, 1'b0, 1'b0, DIR_CW, 1'b1);
        push_event(32'd100, 1'b0, 1'b1, 1'b0, DIR_CW, 1'b0);
        push_event(32'd100, 1'b0, 1'b1, 1'b1, DIR_CW, 1'b0);
        push_event(32'd100, 1'b1, 1'b1, 1'b1, DIR_CCW, 1'b0);
        settle();

        // random phases over several settings
        for (int phase = 0; phase < 8; phase++) begin
            ready_mode  = phase % 4;
            sender_calm = (phase % 4) == 0;
            case (phase)
                0: load_settings(1'b1, 16'd0, 16'd0, 8'd0, 8'd180);
                1: load_settings(1'b0, 16'd10, 16'd0, 8'd1, 8'd1);
                2: load_settings(1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
                3: load_settings(1'b1, 16'd20, 16'd300, 8'd2, 8'd0);
                default: load_settings(1'($urandom), 16'($urandom_range(0, 200)),
                                       16'($urandom_range(0, 3000)),
                                       8'($urandom_range(0, 4)),
                                       8'($urandom_range(1, 180)));
            endcase
            case (phase)
                1: spin_encoder(350, 80);
                2: spin_encoder(200, 15);
                default: spin_encoder(240, $urandom_range(5, 30));
            endcase
            settle();
        end

        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
